@@ rtl/core/mcf_pkg.sv @@
// shared types and constants for the mean curvature flow pass
// used by every module under rtl/core except mcf_ram
package mcf_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int CH_BITS    = 16;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int WID_BITS  = COL_BITS + 1;
	localparam int OROW_BITS = $clog2(MAX_HEIGHT);
	localparam int HGT_BITS  = OROW_BITS + 1;
	localparam int ROW_BITS  = HGT_BITS + 1;

	// register fields as seen on the write port
	localparam int LW_FIELD = 12;
	localparam int FH_FIELD = 13;
	localparam int CFG_BITS = 13;
	localparam int IDX_BITS = 2;

	localparam logic [IDX_BITS-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [WID_BITS-1:0] WIDTH_RESET  = WID_BITS'(640);
	localparam logic [HGT_BITS-1:0] HEIGHT_RESET = HGT_BITS'(480);

	typedef struct packed {
		logic [CH_BITS-1:0] alpha;
		logic [CH_BITS-1:0] blue;
		logic [CH_BITS-1:0] green;
		logic [CH_BITS-1:0] red;
	} pixel_t;

	localparam int PIX_BITS = $bits(pixel_t);

	// three pixels of one column, top to bottom
	typedef pixel_t [2:0] pcol_t;
	// 3x3 neighbourhood, [row][column]
	typedef pixel_t [2:0][2:0] win_t;
	typedef logic [2:0][2:0][CH_BITS-1:0] chan_win_t;

	typedef struct packed {
		logic valid;
		logic last;
	} emit_t;

endpackage

@@ rtl/core/mcf_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mcf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/mcf_front.sv @@
// raster position tracking, line stores and 3x3 window with border replication
// depends on mcf_pkg and mcf_ram
module mcf_front
	import mcf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic                action,
	input  logic [CH_BITS-1:0]  red_in,
	input  logic [CH_BITS-1:0]  green_in,
	input  logic [CH_BITS-1:0]  blue_in,
	input  logic [CH_BITS-1:0]  alpha_in,
	output emit_t               emit,
	output win_t                win,
	input  logic                emit_ready
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_READ = 4'b0010,
		F_TAKE = 4'b0100,
		F_HAND = 4'b1000
	} fstate_t;

	fstate_t                state_q;
	logic [WID_BITS-1:0]    width_q;
	logic [HGT_BITS-1:0]    height_q;
	logic [COL_BITS-1:0]    col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [COL_BITS-1:0]    ocol_q;
	logic [OROW_BITS-1:0]   orow_q;
	pixel_t                 px_q;
	logic                   drain_q;
	logic                   second_q;
	pcol_t [2:0]            wreg_q;
	win_t                   win_q;
	logic                   last_q;

	pixel_t                 up_rd;
	pixel_t                 mid_rd;
	pcol_t                  newcol;
	pcol_t                  left;
	pcol_t                  center;
	pcol_t                  right;
	win_t                   nb;
	logic                   acc;
	logic                   row_full;
	logic                   fire;
	logic                   ocol_first;
	logic                   ocol_last;
	logic                   orow_first;
	logic                   orow_last;
	logic                   closing;
	logic [WID_BITS-1:0]    col_inc;
	logic [WID_BITS-1:0]    ocol_inc;
	logic [LW_FIELD-1:0]    lw_raw;
	logic [FH_FIELD-1:0]    fh_raw;
	logic [WID_BITS-1:0]    lw_eff;
	logic [HGT_BITS-1:0]    fh_eff;
	logic                   wr_en;

	assign wr_en = (state_q == F_TAKE);

	mcf_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_q),
		.wdata (mid_rd),
		.raddr (col_q),
		.rdata (up_rd)
	);

	mcf_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_q),
		.wdata (px_q),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	assign pix_stall = (state_q != F_IDLE);
	assign acc       = pix_valid && (state_q == F_IDLE);
	assign row_full  = row_q >= ROW_BITS'(height_q);

	assign fire = (row_q >= ROW_BITS'(2)) || (row_q == ROW_BITS'(1) && col_q != '0);

	assign ocol_first = (ocol_q == '0);
	assign ocol_last  = ({1'b0, ocol_q} == width_q - WID_BITS'(1));
	assign orow_first = (orow_q == '0);
	assign orow_last  = ({1'b0, orow_q} == height_q - HGT_BITS'(1));
	assign closing    = fire && ocol_last && orow_last;

	assign col_inc  = {1'b0, col_q} + WID_BITS'(1);
	assign ocol_inc = {1'b0, ocol_q} + WID_BITS'(1);

	assign lw_raw = cfg_data[LW_FIELD-1:0];
	assign fh_raw = cfg_data[FH_FIELD-1:0];
	assign lw_eff = (lw_raw == '0) ? WID_BITS'(1) :
		(int'(lw_raw) > MAX_WIDTH) ? WID_BITS'(MAX_WIDTH) : WID_BITS'(lw_raw);
	assign fh_eff = (fh_raw == '0) ? HGT_BITS'(1) :
		(int'(fh_raw) > MAX_HEIGHT) ? HGT_BITS'(MAX_HEIGHT) : HGT_BITS'(fh_raw);

	// window as seen by the pixel leaving now, borders replicated
	always_comb begin
		newcol[0] = up_rd;
		newcol[1] = mid_rd;
		newcol[2] = px_q;
		left      = wreg_q[1];
		center    = wreg_q[2];
		// at column zero the output is the end of the previous row
		right     = (col_q == '0) ? wreg_q[2] : newcol;
		for (int r = 0; r < 3; r++) begin
			nb[r][0] = ocol_first ? center[r] : left[r];
			nb[r][1] = center[r];
			nb[r][2] = ocol_last ? center[r] : right[r];
		end
		for (int k = 0; k < 3; k++) begin
			if (orow_first) begin
				nb[0][k] = nb[1][k];
			end
			if (orow_last) begin
				nb[2][k] = nb[1][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			drain_q  <= 1'b0;
			second_q <= 1'b0;
			wreg_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (acc) begin
						if (!action) begin
							px_q     <= '{alpha: alpha_in, blue: blue_in,
								green: green_in, red: red_in};
							drain_q  <= 1'b0;
							second_q <= 1'b0;
							state_q  <= F_READ;
							if (row_full) begin
								col_q  <= '0;
								row_q  <= '0;
								ocol_q <= '0;
								orow_q <= '0;
							end
						end else if (row_full) begin
							px_q     <= '0;
							drain_q  <= 1'b1;
							second_q <= 1'b0;
							state_q  <= F_READ;
						end
					end
				end
				F_READ: begin
					state_q <= F_TAKE;
				end
				F_TAKE: begin
					wreg_q[0] <= wreg_q[1];
					wreg_q[1] <= wreg_q[2];
					wreg_q[2] <= newcol;
					if (closing) begin
						col_q  <= '0;
						row_q  <= '0;
						ocol_q <= '0;
						orow_q <= '0;
					end else begin
						if (col_inc >= width_q) begin
							col_q <= '0;
							row_q <= row_q + ROW_BITS'(1);
						end else begin
							col_q <= col_inc[COL_BITS-1:0];
						end
						if (fire) begin
							if (ocol_inc >= width_q) begin
								ocol_q <= '0;
								orow_q <= orow_q + OROW_BITS'(1);
							end else begin
								ocol_q <= ocol_inc[COL_BITS-1:0];
							end
						end
					end
					if (fire) begin
						win_q   <= nb;
						last_q  <= closing;
						state_q <= F_HAND;
					end else if (drain_q && !second_q) begin
						second_q <= 1'b1;
						state_q  <= F_READ;
					end else begin
						state_q <= F_IDLE;
					end
				end
				F_HAND: begin
					if (emit_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			if (cfg_we && (cfg_index == REG_LINE_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
				if (cfg_index == REG_LINE_WIDTH) begin
					width_q <= lw_eff;
				end else begin
					height_q <= fh_eff;
				end
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end
		end
	end

	assign emit.valid = (state_q == F_HAND);
	assign emit.last  = last_q;
	assign win        = win_q;

	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < width_q)
		else $error("input column beyond line width");
	a_ocol_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ocol_q} < width_q)
		else $error("output column beyond line width");
	a_orow_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, orow_q} < height_q)
		else $error("output row beyond frame height");

endmodule

@@ rtl/core/mcf_lane.sv @@
// one colour channel of the curvature update: derivatives, products, restoring divide
// depends on mcf_pkg
module mcf_lane
	import mcf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  chan_win_t          nb,
	output logic               ready,
	output logic               done,
	input  logic               take,
	output logic [CH_BITS-1:0] result
);

	typedef enum logic [6:0] {
		L_IDLE  = 7'b0000001,
		L_SQ    = 7'b0000010,
		L_PROD  = 7'b0000100,
		L_SUM   = 7'b0001000,
		L_TOTAL = 7'b0010000,
		L_DIV   = 7'b0100000,
		L_DONE  = 7'b1000000
	} lstate_t;

	localparam int QBITS = CH_BITS + 1;
	localparam int CNT_BITS = $clog2(QBITS);

	lstate_t              state_q;
	logic [CNT_BITS-1:0]  cnt_q;

	logic signed [16:0]   dx_s1, dy_s1;
	logic signed [17:0]   dxx_s1, dyy_s1, q_s1;
	logic [CH_BITS-1:0]   v_s1;

	logic [31:0]          sqx_s2, sqy_s2;
	logic signed [32:0]   pxy_s2;
	logic signed [17:0]   dxx_s2, dyy_s2, q_s2;
	logic [CH_BITS-1:0]   v_s2;

	logic signed [50:0]   a_s3, b_s3, c_s3;
	logic [32:0]          d_s3;
	logic [CH_BITS-1:0]   v_s3;

	logic [48:0]          dv_s4;
	logic [55:0]          part_s4;
	logic [32:0]          d_s4;
	logic [CH_BITS-1:0]   v_s4;

	logic [51:0]          rem_q;
	logic [51:0]          dsh_q;
	logic [QBITS-1:0]     quo_q;
	logic                 neg_q;
	logic                 zero_q;

	logic [16:0]          dx_w, dy_w;
	logic [17:0]          dxx_w, dyy_w, q_w;
	logic signed [33:0]   sqx_w, sqy_w, pxy_w;
	logic signed [50:0]   a_w, b_w, c_w;
	logic [48:0]          dv_w;
	logic [55:0]          part_w;
	logic [55:0]          x_w;

	// differences, wrapped arithmetic read back as two's complement
	assign dx_w  = {1'b0, nb[1][2]} - {1'b0, nb[1][0]};
	assign dy_w  = {1'b0, nb[2][1]} - {1'b0, nb[0][1]};
	assign dxx_w = {2'b0, nb[1][2]} + {2'b0, nb[1][0]} - {1'b0, nb[1][1], 1'b0};
	assign dyy_w = {2'b0, nb[2][1]} + {2'b0, nb[0][1]} - {1'b0, nb[1][1], 1'b0};
	assign q_w   = {2'b0, nb[2][2]} - {2'b0, nb[0][2]} - {2'b0, nb[2][0]} + {2'b0, nb[0][0]};

	assign sqx_w = dx_s1 * dx_s1;
	assign sqy_w = dy_s1 * dy_s1;
	assign pxy_w = dx_s1 * dy_s1;

	assign a_w = $signed({1'b0, sqx_s2}) * dyy_s2;
	assign b_w = $signed({1'b0, sqy_s2}) * dxx_s2;
	assign c_w = pxy_s2 * q_s2;

	assign dv_w = d_s3 * v_s3;

	// 4*dx^2*dyy + 4*dy^2*dxx - 2*dx*dy*q + 8*D
	assign part_w = {{3{a_s3[50]}}, a_s3, 2'b0} + {{3{b_s3[50]}}, b_s3, 2'b0}
		- {{4{c_s3[50]}}, c_s3, 1'b0} + {20'b0, d_s3, 3'b0};

	assign x_w = {3'b0, dv_s4, 4'b0} + part_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					state_q <= L_PROD;
				end
				L_PROD: begin
					state_q <= L_SUM;
				end
				L_SUM: begin
					state_q <= L_TOTAL;
				end
				L_TOTAL: begin
					cnt_q   <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(QBITS - 1)) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (take) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			dx_s1  <= $signed(dx_w);
			dy_s1  <= $signed(dy_w);
			dxx_s1 <= $signed(dxx_w);
			dyy_s1 <= $signed(dyy_w);
			q_s1   <= $signed(q_w);
			v_s1   <= nb[1][1];
		end
		if (state_q == L_SQ) begin
			sqx_s2 <= sqx_w[31:0];
			sqy_s2 <= sqy_w[31:0];
			pxy_s2 <= pxy_w[32:0];
			dxx_s2 <= dxx_s1;
			dyy_s2 <= dyy_s1;
			q_s2   <= q_s1;
			v_s2   <= v_s1;
		end
		if (state_q == L_PROD) begin
			a_s3 <= a_w;
			b_s3 <= b_w;
			c_s3 <= c_w;
			d_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			v_s3 <= v_s2;
		end
		if (state_q == L_SUM) begin
			dv_s4   <= dv_w;
			part_s4 <= part_w;
			d_s4    <= d_s3;
			v_s4    <= v_s3;
		end
		if (state_q == L_TOTAL) begin
			rem_q  <= x_w[55:4];
			dsh_q  <= {3'b0, d_s4, 16'b0};
			quo_q  <= '0;
			neg_q  <= x_w[55];
			zero_q <= (d_s4 == '0);
		end
		if (state_q == L_DIV) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[QBITS-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QBITS-2:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[51:1]};
		end
	end

	assign ready  = (state_q == L_IDLE);
	assign done   = (state_q == L_DONE);
	assign result = zero_q ? v_s4 :
		neg_q ? '0 :
		quo_q[QBITS-1] ? {CH_BITS{1'b1}} : quo_q[CH_BITS-1:0];

endmodule

@@ rtl/core/mean_curvature_flow_pass.sv @@
// One pass of mean curvature flow over a raster RGBA stream. A new pixel is
// taken in a line store read, then a window update; a drain tick may step
// the position twice. A pixel or tick that yields an output hands its 3x3
// window to three channel lanes, which compute differences, squares,
// products, a sum and a total, then run a 17-step restoring divide before
// the result lands in the output register; the front may take further items
// meanwhile but waits for the lanes before handing over the next window, so
// a new window starts only after the lanes hand off their last result. The
// output for pixel k appears after input k + line_width + 1; drain ticks
// after the last pixel of a frame flush the remaining outputs. Line stores
// need no clearing after reset.
// depends on mcf_pkg, mcf_front, mcf_lane
module mean_curvature_flow_pass
	import mcf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic                action,
	input  logic [CH_BITS-1:0]  red_in,
	input  logic [CH_BITS-1:0]  green_in,
	input  logic [CH_BITS-1:0]  blue_in,
	input  logic [CH_BITS-1:0]  alpha_in,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [CH_BITS-1:0]  red_out,
	output logic [CH_BITS-1:0]  green_out,
	output logic [CH_BITS-1:0]  blue_out,
	output logic [CH_BITS-1:0]  alpha_out,
	output logic                frame_end
);

	emit_t                emit;
	win_t                 win;
	logic                 emit_ready;
	logic                 start;
	chan_win_t [2:0]      lane_win;
	logic [2:0]           lane_ready;
	logic [2:0]           lane_done;
	logic [2:0][CH_BITS-1:0] lane_res;
	logic                 load;

	logic [CH_BITS-1:0]   alpha_q;
	logic                 last_q;
	logic                 res_valid_q;
	logic [CH_BITS-1:0]   red_q, green_q, blue_q, alpha_out_q;
	logic                 frame_end_q;

	mcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.action     (action),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.alpha_in   (alpha_in),
		.emit       (emit),
		.win        (win),
		.emit_ready (emit_ready)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				lane_win[0][r][k] = win[r][k].red;
				lane_win[1][r][k] = win[r][k].green;
				lane_win[2][r][k] = win[r][k].blue;
			end
		end
	end

	assign emit_ready = &lane_ready;
	assign start      = emit.valid && emit_ready;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		mcf_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.nb     (lane_win[i]),
			.ready  (lane_ready[i]),
			.done   (lane_done[i]),
			.take   (load),
			.result (lane_res[i])
		);
	end

	// merge the lanes into the output beat
	assign load = (&lane_done) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk) begin
		if (start) begin
			alpha_q <= win[1][1].alpha;
			last_q  <= emit.last;
		end
		if (load) begin
			red_q       <= lane_res[0];
			green_q     <= lane_res[1];
			blue_q      <= lane_res[2];
			alpha_out_q <= alpha_q;
			frame_end_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign alpha_out = alpha_out_q;
	assign frame_end = frame_end_q;

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done == 3'b000 || lane_done == 3'b111)
		else $error("colour lanes out of step");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid &&
		$stable({red_out, green_out, blue_out, alpha_out, frame_end}))
		else $error("result beat changed while stalled");

endmodule
